// ===== rtl/crs_pkg.sv =====
// Shared types, constants and character helpers for the cell reference shifter.
// No dependencies; compiled first.
package crs_pkg;

    localparam int MaxCols    = 256;
    localparam int MaxLetters = 2;
    localparam int MaxDigits  = 5;
    localparam int BufDepth   = 10;
    localparam int RowDigits  = 5;

    localparam logic [7:0] ChDollar = 8'h24;
    localparam logic [7:0] ChBang   = 8'h21;
    localparam logic [7:0] ChColon  = 8'h3A;
    localparam logic [7:0] ChUpperA = 8'h41;
    localparam logic [7:0] ChZero   = 8'h30;

    typedef enum logic [1:0] {
        REG_ROW_CUT,
        REG_ROW_OFFSET,
        REG_COL_CUT,
        REG_COL_OFFSET
    } t_reg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DOLLAR,
        PH_LETTERS,
        PH_WORD,
        PH_RDOLLAR,
        PH_DIGITS
    } t_phase;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_EMIT,
        ACT_PUSH,
        ACT_WORDEND,
        ACT_DOLLAR,
        ACT_FLUSH,
        ACT_FLUSHWORD,
        ACT_SPLITR,
        ACT_SPLITD,
        ACT_FINISH
    } t_act;

    typedef enum logic [2:0] {
        SRC_C,
        SRC_DOLLAR,
        SRC_BUF,
        SRC_COLHI,
        SRC_COLLO,
        SRC_ROW
    } t_src;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_CONV,
        ST_RCD,
        ST_RCH,
        ST_RCL,
        ST_RRD,
        ST_RROW,
        ST_POST,
        ST_END
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       emit;
        t_src       src;
        logic [3:0] idx;
        logic       apply;
        logic       eof;
        logic       ref_start;
        logic       conv_step;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        t_act       act;
        logic       again;
        logic [3:0] flush_n;
        logic       col_abs;
        logic       row_abs;
        logic       two_letters;
        logic       conv_last;
        logic [2:0] nd;
        logic       emit_rdy;
        logic       slot_free;
        logic       hold_v;
        logic       fin;
    } t_sts;

    function automatic logic char_is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic char_is_numeral(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [4:0] letter_val(input logic [7:0] c);
        logic [7:0] u;
        u = c & 8'hDF;
        return 5'(u - 8'h40);
    endfunction

endpackage

// ===== rtl/crs_ifs.sv =====
// Valid/ready channel interfaces for the character input and result output.
// No dependencies.
interface crs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       final_char;
    modport source (output valid, text_char, final_char, input ready);
    modport sink   (input valid, text_char, final_char, output ready);
endinterface

interface crs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       text_done;
    logic       any_moved;
    modport source (output valid, out_char, char_valid, run_last, text_done, any_moved,
                    input ready);
    modport sink   (input valid, out_char, char_valid, run_last, text_done, any_moved,
                    output ready);
endinterface

// ===== rtl/crs_dp.sv =====
// Datapath: config registers, token buffer, scanner state, row/column arithmetic,
// hold and output registers. Depends on crs_pkg.
module crs_dp
    import crs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [7:0]  i_text_char,
    input  logic        i_final_char,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [7:0]  o_out_char,
    output logic        o_char_valid,
    output logic        o_run_last,
    output logic        o_text_done,
    output logic        o_any_moved,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam logic signed [11:0] ColLim = 12'(MaxCols);

    logic [15:0]        r_row_cut, r_col_cut;
    logic signed [7:0]  r_row_off, r_col_off;
    logic [7:0]         r_c;
    logic               r_fin;
    logic [7:0]         r_buf [BufDepth];
    logic [3:0]         r_len;
    t_phase             r_phase;
    logic               r_skip, r_moved, r_cabs, r_rabs;
    logic [9:0]         r_col;
    logic [15:0]        r_row;
    logic [1:0]         r_lcnt;
    logic [2:0]         r_dcnt;
    logic [15:0]        r_conv;
    logic [9:0]         r_colv;
    logic [3:0]         r_dig [RowDigits];
    logic [2:0]         r_nd;
    logic [7:0]         r_hold;
    logic               r_hold_v;
    logic               r_ovalid, r_ocv, r_olast, r_odone, r_omoved;
    logic [7:0]         r_ochar;

    logic               c_alpha, c_digit;
    logic [4:0]         c_lv;
    logic [3:0]         c_dv;
    logic [19:0]        w_rmul;
    logic [15:0]        w_rnext;
    logic [9:0]         w_cnext;
    logic signed [17:0] w_rsum;
    logic [9:0]         w_colz;
    logic signed [11:0] w_csum;
    logic               w_mr, w_mc, w_move;
    logic [15:0]        w_rowv;
    logic [9:0]         w_colv;
    t_act               w_act;
    logic               w_again, w_clear;
    logic [3:0]         w_flush_n;
    logic [32:0]        w_qprod;
    logic [15:0]        w_q;
    logic [3:0]         w_d;
    logic [21:0]        w_cprod;
    logic [4:0]         w_cq, w_lo, w_hi;
    logic [7:0]         w_char;
    logic               w_slot_free, w_emit_rdy;

    assign c_alpha = char_is_letter(r_c);
    assign c_digit = char_is_numeral(r_c);
    assign c_lv    = letter_val(r_c);
    assign c_dv    = r_c[3:0];

    assign w_rmul  = 20'(r_row) * 20'd10 + 20'(c_dv);
    assign w_rnext = (w_rmul > 20'h0FFFF) ? 16'hFFFF : w_rmul[15:0];
    assign w_cnext = 10'(r_col * 10'd26) + 10'(c_lv);

    assign w_rsum = $signed({2'b00, r_row}) + 18'(r_row_off);
    assign w_mr   = (r_row_off != 8'sd0) && !r_rabs && (r_row != 16'd0)
                 && (r_row != 16'hFFFF) && (r_row > r_row_cut)
                 && (w_rsum >= 18'sd1) && (w_rsum <= 18'sd65535);
    assign w_colz = r_col - 10'd1;
    assign w_csum = $signed({2'b00, w_colz}) + 12'(r_col_off);
    assign w_mc   = (r_col_off != 8'sd0) && !r_cabs && ({6'b0, w_colz} >= r_col_cut)
                 && (w_csum >= 12'sd0) && (w_csum < ColLim);
    assign w_move = w_mr || w_mc;
    assign w_rowv = w_mr ? w_rsum[15:0] : r_row;
    assign w_colv = w_mc ? w_csum[9:0] : w_colz;

    always_comb begin
        w_act = ACT_NONE;
        if (i_cmd.eof) begin
            case (r_phase)
                PH_DIGITS:        w_act = ACT_FINISH;
                PH_IDLE, PH_WORD: w_act = ACT_NONE;
                default:          w_act = ACT_FLUSH;
            endcase
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    w_act = (r_c == ChDollar || c_alpha) ? ACT_PUSH : ACT_EMIT;
                end
                PH_DOLLAR: begin
                    w_act = c_alpha ? ACT_PUSH : ACT_DOLLAR;
                end
                PH_LETTERS: begin
                    if (c_alpha) begin
                        w_act = (r_lcnt < 2'(MaxLetters)) ? ACT_PUSH : ACT_FLUSHWORD;
                    end else if (r_c == ChDollar || c_digit) begin
                        w_act = ACT_PUSH;
                    end else begin
                        w_act = ACT_FLUSH;
                    end
                end
                PH_WORD: begin
                    w_act = c_alpha ? ACT_EMIT : ACT_WORDEND;
                end
                PH_RDOLLAR: begin
                    w_act = c_digit ? ACT_PUSH : ACT_SPLITR;
                end
                default: begin
                    if (c_digit && r_dcnt < 3'(MaxDigits)) begin
                        w_act = ACT_PUSH;
                    end else if (c_alpha || c_digit) begin
                        w_act = ACT_SPLITD;
                    end else begin
                        w_act = ACT_FINISH;
                    end
                end
            endcase
        end
    end

    always_comb begin
        w_again   = 1'b1;
        w_clear   = 1'b1;
        w_flush_n = 4'd0;
        case (w_act)
            ACT_EMIT, ACT_PUSH: begin
                w_again = 1'b0;
                w_clear = 1'b0;
            end
            ACT_WORDEND:   w_clear = 1'b0;
            ACT_FLUSHWORD: begin
                w_again   = 1'b0;
                w_flush_n = r_len;
            end
            ACT_FLUSH, ACT_SPLITD: w_flush_n = r_len;
            ACT_SPLITR:    w_flush_n = r_len - 4'd1;
            ACT_FINISH:    w_flush_n = (w_move && !r_skip) ? 4'd0 : r_len;
            default:       w_again = 1'b1;
        endcase
    end

    // row digits by reciprocal of ten, column letters by reciprocal of 26
    assign w_qprod = 33'(r_conv) * 33'd52429;
    assign w_q     = 16'(w_qprod >> 19);
    assign w_d     = 4'(r_conv - 16'(w_q * 16'd10));
    assign w_cprod = 22'(r_colv) * 22'd2521;
    assign w_cq    = 5'(w_cprod >> 16);
    assign w_lo    = 5'(r_colv - 10'(w_cq * 10'd26));
    assign w_hi    = w_cq - 5'd1;

    always_comb begin
        case (i_cmd.src)
            SRC_C:      w_char = r_c;
            SRC_DOLLAR: w_char = ChDollar;
            SRC_BUF:    w_char = r_buf[i_cmd.idx];
            SRC_COLHI:  w_char = ChUpperA + {3'b000, w_hi};
            SRC_COLLO:  w_char = ChUpperA + {3'b000, w_lo};
            SRC_ROW:    w_char = ChZero + {4'b0000, r_dig[i_cmd.idx[2:0]]};
            default:    w_char = r_c;
        endcase
    end

    assign w_slot_free = !r_ovalid || i_out_ready;
    assign w_emit_rdy  = !r_hold_v || w_slot_free;

    always_comb begin
        o_sts             = '0;
        o_sts.act         = w_act;
        o_sts.again       = w_again;
        o_sts.flush_n     = w_flush_n;
        o_sts.col_abs     = r_cabs;
        o_sts.row_abs     = r_rabs;
        o_sts.two_letters = r_colv >= 10'd26;
        o_sts.conv_last   = w_q == 16'd0;
        o_sts.nd          = r_nd;
        o_sts.emit_rdy    = w_emit_rdy;
        o_sts.slot_free   = w_slot_free;
        o_sts.hold_v      = r_hold_v;
        o_sts.fin         = r_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cut <= '0;
            r_col_cut <= '0;
            r_row_off <= '0;
            r_col_off <= '0;
            r_len     <= '0;
            r_phase   <= PH_IDLE;
            r_skip    <= 1'b0;
            r_moved   <= 1'b0;
            r_cabs    <= 1'b0;
            r_rabs    <= 1'b0;
            r_col     <= '0;
            r_row     <= '0;
            r_lcnt    <= '0;
            r_dcnt    <= '0;
            r_hold_v  <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_idx))
                    REG_ROW_CUT:    r_row_cut <= i_cfg_data;
                    REG_ROW_OFFSET: r_row_off <= i_cfg_data[7:0];
                    REG_COL_CUT:    r_col_cut <= i_cfg_data;
                    REG_COL_OFFSET: r_col_off <= i_cfg_data[7:0];
                    default:        r_row_cut <= r_row_cut;
                endcase
            end

            if (i_cmd.accept) begin
                r_c   <= i_text_char;
                r_fin <= i_final_char;
            end

            if (i_cmd.apply) begin
                if (w_clear) begin
                    // lone row dollar left over: rescanned as a column dollar
                    r_len   <= (w_act == ACT_SPLITR) ? 4'd1 : 4'd0;
                    r_lcnt  <= '0;
                    r_dcnt  <= '0;
                    r_col   <= '0;
                    r_row   <= '0;
                    r_cabs  <= (w_act == ACT_SPLITR);
                    r_rabs  <= 1'b0;
                    case (w_act)
                        ACT_FLUSHWORD: r_phase <= PH_WORD;
                        ACT_SPLITR:    r_phase <= PH_DOLLAR;
                        default:       r_phase <= PH_IDLE;
                    endcase
                end
                case (w_act)
                    ACT_EMIT: begin
                        if (r_phase == PH_IDLE && r_c == ChBang) r_skip <= 1'b1;
                    end
                    ACT_PUSH: begin
                        if (r_len < 4'(BufDepth)) begin
                            r_buf[r_len] <= r_c;
                            r_len        <= r_len + 4'd1;
                        end
                        case (r_phase)
                            PH_IDLE, PH_DOLLAR: begin
                                if (r_c == ChDollar) begin
                                    r_cabs  <= 1'b1;
                                    r_phase <= PH_DOLLAR;
                                end else begin
                                    r_lcnt  <= 2'd1;
                                    r_col   <= 10'(c_lv);
                                    r_phase <= PH_LETTERS;
                                end
                            end
                            PH_LETTERS: begin
                                if (c_alpha) begin
                                    r_lcnt <= r_lcnt + 2'd1;
                                    r_col  <= w_cnext;
                                end else if (r_c == ChDollar) begin
                                    r_rabs  <= 1'b1;
                                    r_phase <= PH_RDOLLAR;
                                end else begin
                                    r_dcnt  <= 3'd1;
                                    r_row   <= 16'(c_dv);
                                    r_phase <= PH_DIGITS;
                                end
                            end
                            PH_RDOLLAR: begin
                                r_dcnt  <= 3'd1;
                                r_row   <= 16'(c_dv);
                                r_phase <= PH_DIGITS;
                            end
                            default: begin
                                r_dcnt <= r_dcnt + 3'd1;
                                r_row  <= w_rnext;
                            end
                        endcase
                    end
                    ACT_WORDEND: r_phase <= PH_IDLE;
                    ACT_SPLITR:  r_buf[0] <= ChDollar;
                    ACT_FINISH: begin
                        if (r_skip) r_skip <= (r_c == ChColon) && !i_cmd.eof;
                        else if (w_move) r_moved <= 1'b1;
                    end
                    default: ;
                endcase
            end

            if (i_cmd.ref_start) begin
                r_conv <= w_rowv;
                r_colv <= w_colv;
                r_nd   <= '0;
            end
            if (i_cmd.conv_step) begin
                r_dig[r_nd] <= w_d;
                r_nd        <= r_nd + 3'd1;
                r_conv      <= w_q;
            end

            if ((i_cmd.emit && w_emit_rdy && r_hold_v)
                    || (i_cmd.finish && (r_hold_v || r_fin))) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.emit && w_emit_rdy) begin
                if (r_hold_v) begin
                    r_ochar  <= r_hold;
                    r_ocv    <= 1'b1;
                    r_olast  <= 1'b0;
                    r_odone  <= 1'b0;
                    r_omoved <= 1'b0;
                end
                r_hold   <= w_char;
                r_hold_v <= 1'b1;
            end
            if (i_cmd.finish) begin
                if (r_hold_v) begin
                    r_ochar  <= r_hold;
                    r_ocv    <= 1'b1;
                    r_olast  <= 1'b1;
                    r_odone  <= r_fin;
                    r_omoved <= r_fin && r_moved;
                    r_hold_v <= 1'b0;
                end else if (r_fin) begin
                    r_ochar  <= 8'h00;
                    r_ocv    <= 1'b0;
                    r_olast  <= 1'b1;
                    r_odone  <= 1'b1;
                    r_omoved <= r_moved;
                end
                if (r_fin) begin
                    r_moved <= 1'b0;
                    r_skip  <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_char   = r_ochar;
    assign o_char_valid = r_ocv;
    assign o_run_last   = r_olast;
    assign o_text_done  = r_odone;
    assign o_any_moved  = r_omoved;

endmodule

// ===== rtl/crs_ctrl.sv =====
// Controller: sequences scan, buffer flush, row conversion and reference rewrite.
// Depends on crs_pkg.
module crs_ctrl
    import crs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [3:0] r_idx, n_idx;
    logic       r_eof, n_eof;
    logic       w_need;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_eof   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_eof   <= n_eof;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_eof      = r_eof;
        o_cmd      = '0;
        o_cmd.eof  = r_eof;
        o_cmd.idx  = r_idx;
        o_in_ready = 1'b0;
        w_need     = (i_sts.act == ACT_EMIT) || (i_sts.act == ACT_FLUSHWORD)
                  || (i_sts.act == ACT_DOLLAR);
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_eof        = 1'b0;
                    n_state      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.flush_n != 4'd0) begin
                    n_idx   = '0;
                    n_state = ST_FLUSH;
                end else if (i_sts.act == ACT_FINISH) begin
                    o_cmd.ref_start = 1'b1;
                    n_state         = ST_CONV;
                end else begin
                    n_state = ST_POST;
                end
            end
            ST_FLUSH: begin
                o_cmd.emit = 1'b1;
                o_cmd.src  = SRC_BUF;
                if (i_sts.emit_rdy) begin
                    if (r_idx == i_sts.flush_n - 4'd1) n_state = ST_POST;
                    else n_idx = r_idx + 4'd1;
                end
            end
            ST_CONV: begin
                o_cmd.conv_step = 1'b1;
                if (i_sts.conv_last) begin
                    n_idx   = {1'b0, i_sts.nd};
                    n_state = ST_RCD;
                end
            end
            ST_RCD: begin
                if (i_sts.col_abs) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_DOLLAR;
                    if (i_sts.emit_rdy) n_state = ST_RCH;
                end else begin
                    n_state = ST_RCH;
                end
            end
            ST_RCH: begin
                if (i_sts.two_letters) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_COLHI;
                    if (i_sts.emit_rdy) n_state = ST_RCL;
                end else begin
                    n_state = ST_RCL;
                end
            end
            ST_RCL: begin
                o_cmd.emit = 1'b1;
                o_cmd.src  = SRC_COLLO;
                if (i_sts.emit_rdy) n_state = ST_RRD;
            end
            ST_RRD: begin
                if (i_sts.row_abs) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_DOLLAR;
                    if (i_sts.emit_rdy) n_state = ST_RROW;
                end else begin
                    n_state = ST_RROW;
                end
            end
            ST_RROW: begin
                o_cmd.emit = 1'b1;
                o_cmd.src  = SRC_ROW;
                if (i_sts.emit_rdy) begin
                    if (r_idx == 4'd0) n_state = ST_POST;
                    else n_idx = r_idx - 4'd1;
                end
            end
            ST_POST: begin
                o_cmd.emit = w_need;
                o_cmd.src  = (i_sts.act == ACT_DOLLAR) ? SRC_DOLLAR : SRC_C;
                if (!w_need || i_sts.emit_rdy) begin
                    o_cmd.apply = 1'b1;
                    if (!r_eof && i_sts.again) begin
                        n_state = ST_SCAN;
                    end else if (i_sts.fin && !r_eof) begin
                        n_eof   = 1'b1;
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_END;
                    end
                end
            end
            ST_END: begin
                if (!((i_sts.hold_v || i_sts.fin) && !i_sts.slot_free)) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/cell_reference_shifter.sv =====
// Top level of the cell reference shifter: controller, datapath and channel ports.
// Depends on crs_pkg, crs_ifs, crs_ctrl and crs_dp.

// Rewrites formula text one character per input transaction, moving relative cell
// references past the cut row or at or past the cut column by the programmed offsets.
// Input is taken only while the block is idle: a character that is held in the token
// buffer or passed straight through goes through the accept, scan, commit and finish
// steps before the next can be taken, and the last character of a formula adds an
// end-of-text pass. Characters are flushed from the token buffer one at a time, a
// rejected candidate is rescanned through scan and commit again, and a rewritten
// reference converts its row one decimal digit at a time (up to five digits), then
// emits the column dollar, column letters, row dollar and row digits. Output stalls
// hold the sequence. The last character of each input is held back one result
// so that run_last can be flagged; results leave through a registered output stage.
module cell_reference_shifter
    import crs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    crs_in_if.sink      i_chan,
    crs_out_if.source   o_chan,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    crs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_chan.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    crs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_text_char  (i_chan.text_char),
        .i_final_char (i_chan.final_char),
        .i_out_ready  (o_chan.ready),
        .o_out_valid  (o_chan.valid),
        .o_out_char   (o_chan.out_char),
        .o_char_valid (o_chan.char_valid),
        .o_run_last   (o_chan.run_last),
        .o_text_done  (o_chan.text_done),
        .o_any_moved  (o_chan.any_moved),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    assign i_chan.ready = w_in_ready;

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_chan.valid && o_chan.text_done |-> o_chan.run_last)
        else $error("text_done without run_last");

    a_moved_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_chan.valid && o_chan.any_moved |-> o_chan.text_done)
        else $error("any_moved outside text_done");

    a_empty_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_chan.valid && !o_chan.char_valid |-> o_chan.text_done && o_chan.out_char == 8'h00)
        else $error("empty result not at end of formula");

    a_hold_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_chan.ready |-> !w_sts.hold_v)
        else $error("held character left over when taking new input");

endmodule
